// ----- rtl/pdec_pkg.sv -----
// ----------------------------------------------------------------------------
// pdec_pkg
// Shared types, character constants and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pdec_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam int unsigned HexRadixLog2 = 4;  // radix 16

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepthDefault = 2;

  // One queued command. A pair word emits a literal '%' first, then data.
  typedef struct packed {
    logic       pair;
    logic [7:0] data;
    logic       last;
  } pdec_cmd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } pdec_hex_t;

  function automatic pdec_hex_t hex_digit(input logic [7:0] c);
    pdec_hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c == ChSpace) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == ChPlus) ? ChSpace : c;
  endfunction

  // strtol-like parse of the two bytes after '%', wrapped to 8 bits.
  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    pdec_hex_t  ha;
    pdec_hex_t  hb;
    logic [7:0] single;
    logic [7:0] r;
    ha     = hex_digit(a);
    hb     = hex_digit(b);
    single = hb.ok ? {4'd0, hb.val} : 8'd0;
    if (is_white(a) || a == ChPlus) begin
      r = single;
    end else if (a == ChMinus) begin
      r = 8'(8'd0 - single);
    end else if (!ha.ok) begin
      r = 8'd0;
    end else if (!hb.ok) begin
      r = {4'd0, ha.val};
    end else begin
      r = 8'({4'd0, ha.val} << HexRadixLog2) | {4'd0, hb.val};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/percent_decoder_core.sv -----
// ----------------------------------------------------------------------------
// percent_decoder_core
// Form-urlencoded percent decoder: '+' to space, %XY to one byte.
// ----------------------------------------------------------------------------
// Path: a word that completes a result is written into the queue at the edge that
//   takes it, then loaded into the output register when the back end is free.
// Throughput: one input word per cycle unless the queue is full; one output word
//   per cycle unless the master stalls. A '%' one before the end gives two words.
// Reset: rst_ni clears the escape tracker, the queue pointers and the output
//   valid; no escape is pending after reset.
`default_nettype none

module percent_decoder_core #(
  parameter int unsigned QueueDepth = pdec_pkg::QueueDepthDefault  // >= 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // slave side
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  // master side
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast    // out_last
);
  import pdec_pkg::*;

  // Front -> queue
  logic      push;
  pdec_cmd_t push_cmd;
  logic      q_full;

  // Queue -> back
  logic      q_empty;
  logic      pop;
  pdec_cmd_t head;

  // Front: tracks '%' and the first hex byte, turns each word into at most
  // one queued command (a pair command carries the stream-end literal '%').
  pdec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Queue decouples the front from output backpressure.
  pdec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  // Back: registered output word; splits pair commands into two words.
  pdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/pdec_front.sv -----
// ----------------------------------------------------------------------------
// pdec_front
// Takes input words, tracks the escape sequence and queues output commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pdec_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               in_last_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output pdec_pkg::pdec_cmd_t     cmd_o
);
  import pdec_pkg::*;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhPct   = 2'd1;
  localparam logic [1:0] PhFirst = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    push_o   = 1'b0;
    cmd_o    = '{pair: 1'b0, data: plain_byte(in_byte_i), last: in_last_i};
    if (accept) begin
      unique case (phase_q)
        PhPct: begin
          if (in_last_i) begin
            push_o   = 1'b1;
            cmd_o.pair = 1'b1;
            phase_d  = PhIdle;
          end else begin
            first_d  = in_byte_i;
            phase_d  = PhFirst;
          end
        end
        PhFirst: begin
          push_o     = 1'b1;
          cmd_o.data = pair_value(first_q, in_byte_i);
          phase_d    = PhIdle;
        end
        default: begin
          phase_d = PhIdle;
          if (in_byte_i == ChPercent) begin
            if (in_last_i) begin
              push_o     = 1'b1;
              cmd_o.data = ChPercent;
            end else begin
              phase_d = PhPct;
            end
          end else begin
            push_o = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      first_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pdec_fifo.sv -----
// ----------------------------------------------------------------------------
// pdec_fifo
// Short first-word-fall-through queue of commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pdec_fifo #(
  parameter int unsigned Depth = pdec_pkg::QueueDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire pdec_pkg::pdec_cmd_t  push_cmd_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output pdec_pkg::pdec_cmd_t       head_o
);
  import pdec_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  pdec_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ----- rtl/pdec_back.sv -----
// ----------------------------------------------------------------------------
// pdec_back
// Drains queued commands into the registered output word, splitting pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module pdec_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 empty_i,
  input  wire pdec_pkg::pdec_cmd_t  head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      out_last_o
);
  import pdec_pkg::*;

  logic       valid_q;
  logic       pend_q;     // second word of a pair still owed
  logic [7:0] pend_byte_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign load        = !valid_q || out_ready_i;
  assign pop_o       = load && !pend_q && !empty_i;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= !empty_i;
        pend_q  <= !empty_i && head_i.pair;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        byte_q <= pend_byte_q;
        last_q <= 1'b1;
      end else if (head_i.pair) begin
        byte_q      <= ChPercent;
        last_q      <= 1'b0;
        pend_byte_q <= head_i.data;
      end else begin
        byte_q <= head_i.data;
        last_q <= head_i.last;
      end
    end
  end

  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> valid_q)
    else $error("pair tail owed without a word on the output");
  a_pend_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (byte_q == ChPercent) && !last_q)
    else $error("pair head is not a plain percent");

endmodule

`default_nettype wire

// ----- sim/percent_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// percent_decoder_core_tb
// Self-checking bench for the form-urlencoded decoder. Encoded text goes in
// one word at a time with tlast on the final byte. A scoreboard predicts the
// decoded words and checks every word taken from the master side, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module percent_decoder_core_tb;

  import pdec_pkg::*;

  // One decoded word as seen on the master side.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_word_t;

  // Escape tracker of the predictor. The fourth code never arises.
  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,  // no escape pending
    ESC_PERCENT = 2'd1,  // '%' taken
    ESC_FIRST   = 2'd2   // '%' and the first byte of the pair taken
  } esc_phase_e;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the escape state, queues the decoded words each input
  // word releases, and compares master-side words with the oldest one queued.
  // --------------------------------------------------------------------------
  class decode_scoreboard;
    dec_word_t   expected_q[$];
    esc_phase_e  phase;
    logic [7:0]  held_byte;
    int unsigned errors;

    function new();
      phase     = ESC_NONE;
      held_byte = 8'h00;
      errors    = 0;
    endfunction

    // -1 when c is not a hex digit
    function int hex_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function logic is_blank(input logic [7:0] c);
      return (c == ChSpace) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Base-16 parse of the two bytes behind a '%': optional blank or sign,
    // stop at the first non-hex byte, no digits gives zero.
    function logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
      int         va;
      int         vb;
      logic [7:0] lone;
      va   = hex_val(a);
      vb   = hex_val(b);
      lone = (vb >= 0) ? 8'(vb) : 8'h00;
      if (is_blank(a) || a == ChPlus) return lone;
      if (a == ChMinus) return 8'h00 - lone;
      if (va < 0) return 8'h00;
      if (vb < 0) return 8'(va);
      return 8'(va * 16 + vb);
    endfunction

    function logic [7:0] unplus(input logic [7:0] c);
      return (c == ChPlus) ? ChSpace : c;
    endfunction

    function void push(input logic [7:0] d, input logic l);
      dec_word_t w;
      w.data = d;
      w.last = l;
      expected_q.push_back(w);
    endfunction

    // Called for every word accepted on the slave side.
    function void note_input(input logic [7:0] b, input logic l);
      case (phase)
        ESC_PERCENT: begin
          if (l) begin
            // '%' one before the end: literal '%', then the final byte
            push(ChPercent, 1'b0);
            push(unplus(b), 1'b1);
            phase = ESC_NONE;
          end else begin
            held_byte = b;
            phase     = ESC_FIRST;
          end
        end
        ESC_FIRST: begin
          push(decode_pair(held_byte, b), l);
          phase = ESC_NONE;
        end
        default: begin
          phase = ESC_NONE;
          if (b == ChPercent) begin
            if (l) push(ChPercent, 1'b1);  // '%' on the last byte stays literal
            else   phase = ESC_PERCENT;
          end else begin
            push(unplus(b), l);
          end
        end
      endcase
    endfunction

    // Called for every word accepted on the master side.
    function void check_output(input logic [7:0] d, input logic l);
      dec_word_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual data %02h last %0b",
                 $time, d, l);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (d !== w.data) begin
        $display("%0t: data mismatch: expected %02h, actual %02h", $time, w.data, d);
        errors++;
      end
      if (l !== w.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, w.last, l);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals; every block input is known from time zero
  // --------------------------------------------------------------------------
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;   // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // out_last

  // chance in percent that the sender idles / the receiver stalls per cycle
  int unsigned src_gap_pct    = 25;
  int unsigned sink_stall_pct = 78;

  decode_scoreboard decoded_words = new();

  percent_decoder_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: take words at the edge, then pick next cycle's tready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      decoded_words.check_output(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Present one word (after random idle cycles) and hold it until taken.
  task automatic send_word(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decoded_words.note_input(b, l);
  endtask

  // Whole string, tlast on its final byte.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], i == s.len() - 1);
    end
  endtask

  // Text-like byte: plenty of '%' and hex digits so escapes get exercised,
  // plus blanks, signs, 'x' and arbitrary bytes.
  function automatic logic [7:0] text_byte();
    string       hexset;
    string       oddset;
    int unsigned r;
    hexset = "0123456789abcdefABCDEF";
    oddset = " \t\n\v\f\r-+x0";
    r      = $urandom_range(0, 99);
    if (r < 22) return ChPercent;
    if (r < 32) return ChPlus;
    if (r < 57) return hexset[$urandom_range(0, hexset.len() - 1)];
    if (r < 70) return oddset[$urandom_range(0, oddset.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short strings of text-like bytes; some raw noise words with a
  // random tlast, which also breaks escapes at odd places.
  task automatic send_random_text(input int unsigned n_words);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        sent++;
      end else begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          send_word(text_byte(), i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles a quarter of the time, receiver stalls often
    src_gap_pct    = 25;
    sink_stall_pct = 78;

    // directed: byte extremes, '%' on the last byte, '%' one before the end,
    // completed escapes with blank, sign, '0x', mixed case and non-hex bytes
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_text("%");
    send_text("%+");
    send_text("%4f");
    send_text("%-1+");
    send_text("% F");
    send_text("%+f");
    send_text("%0x%aG");
    send_random_text(165);

    // the other way round: slow sender, eager receiver
    src_gap_pct    = 78;
    sink_stall_pct = 25;
    send_random_text(165);

    // full rate on both sides
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    send_random_text(165);
    s_axis_tvalid <= 1'b0;

    while (decoded_words.pending() != 0) @(posedge clk_i);
    // let any stray word surface
    repeat (10) @(posedge clk_i);

    if (decoded_words.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
